### rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, register indexes, stage types and rounding and saturation
// helpers for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  // operand and intermediate widths
  localparam int QW   = 16;            // quaternion component, Q1.14
  localparam int PW   = 32;            // point coordinate, Q16.16
  localparam int P1W  = QW + PW;       // q * p product
  localparam int S1W  = P1W + 2;       // sum of three q * p products
  localparam int TW   = 36;            // first product component, Q20.16
  localparam int P2W  = TW + QW;       // t * q product
  localparam int S2W  = P2W + 2;       // sum of four t * q products
  localparam int RSH  = 14;            // Q.30 -> Q.16
  localparam int RW   = S2W - RSH;     // rounded second-product width
  localparam int OW   = 32;            // output coordinate
  localparam int WW   = 17;            // homogeneous w
  localparam int IDXW = 2;             // config register index

  localparam int RND_HALF = 1 << (RSH - 1);

  localparam logic [WW-1:0] W_ONE  = WW'(1 << 16);
  localparam logic [WW-1:0] W_ZERO = '0;

  localparam logic signed [QW-1:0] ROT_W_RESET = QW'(1 << RSH);

  localparam logic signed [RW-1:0] SAT_MAX = {{(RW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_MIN = {{(RW - OW + 1){1'b1}}, {(OW - 1){1'b0}}};

  typedef enum logic [IDXW-1:0] {
    REG_ROT_X = 2'd0,
    REG_ROT_Y = 2'd1,
    REG_ROT_Z = 2'd2,
    REG_ROT_W = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  // word handed from the first Hamilton product to the second
  typedef struct packed {
    logic signed [TW-1:0] tx;
    logic signed [TW-1:0] ty;
    logic signed [TW-1:0] tz;
    logic signed [TW-1:0] tw;
    logic                 is_point;
  } tvec_t;

  typedef struct packed {
    logic                 clip;
    logic signed [OW-1:0] val;
  } sat_t;

  // round half up: floor((s + 2^13) / 2^14)
  function automatic logic signed [TW-1:0] round_t(input logic signed [S1W-1:0] s);
    logic signed [S1W-1:0] r;
    begin
      r = s + S1W'(RND_HALF);
      round_t = TW'(r >>> RSH);
    end
  endfunction

  function automatic logic signed [RW-1:0] round_r(input logic signed [S2W-1:0] s);
    logic signed [S2W-1:0] r;
    begin
      r = s + S2W'(RND_HALF);
      round_r = RW'(r >>> RSH);
    end
  endfunction

  function automatic sat_t sat_out(input logic signed [RW-1:0] v);
    sat_t o;
    begin
      if (v > SAT_MAX) begin
        o.clip = 1'b1;
        o.val  = OW'(SAT_MAX);
      end else if (v < SAT_MIN) begin
        o.clip = 1'b1;
        o.val  = OW'(SAT_MIN);
      end else begin
        o.clip = 1'b0;
        o.val  = OW'(v);
      end
      sat_out = o;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/qvr_in_if.sv
// ----------------------------------------------------------------------------
// qvr_in_if
// Input channel: one point word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qvr_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [qvr_pkg::PW-1:0]   point_x;
  logic signed [qvr_pkg::PW-1:0]   point_y;
  logic signed [qvr_pkg::PW-1:0]   point_z;
  logic                            is_point;

  modport source (output valid, point_x, point_y, point_z, is_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, is_point, output ready);
endinterface

`default_nettype wire

### rtl/qvr_out_if.sv
// ----------------------------------------------------------------------------
// qvr_out_if
// Result channel: one rotated point word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qvr_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [qvr_pkg::OW-1:0]   out_x;
  logic signed [qvr_pkg::OW-1:0]   out_y;
  logic signed [qvr_pkg::OW-1:0]   out_z;
  logic        [qvr_pkg::WW-1:0]   out_w;
  logic                            saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

`default_nettype wire

### rtl/qvr_tprod.sv
// ----------------------------------------------------------------------------
// qvr_tprod
// First Hamilton product t = q * (p, 0): a multiply stage and a sum/round
// stage, each with its own valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_tprod (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire qvr_pkg::quat_t  q,
  qvr_in_if.sink               in_chan,
  output logic                 t_valid,
  input  wire logic            t_ready,
  output qvr_pkg::tvec_t       t_word
);

  localparam int P1W = qvr_pkg::P1W;
  localparam int S1W = qvr_pkg::S1W;

  logic v1_r, v2_r;
  logic adv1, adv2;

  logic signed [P1W-1:0] m_xx_r, m_xy_r, m_xz_r;
  logic signed [P1W-1:0] m_yx_r, m_yy_r, m_yz_r;
  logic signed [P1W-1:0] m_zx_r, m_zy_r, m_zz_r;
  logic signed [P1W-1:0] m_wx_r, m_wy_r, m_wz_r;
  logic                  pt1_r;

  logic signed [S1W-1:0] sx, sy, sz, sw;
  qvr_pkg::tvec_t        t_r, t_nxt;

  // a stage moves when it is empty or the next one moves
  assign adv2          = !v2_r || t_ready;
  assign adv1          = !v1_r || adv2;
  assign in_chan.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_chan.valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_chan.valid) begin
      m_xx_r <= P1W'(q.x) * P1W'(in_chan.point_x);
      m_xy_r <= P1W'(q.x) * P1W'(in_chan.point_y);
      m_xz_r <= P1W'(q.x) * P1W'(in_chan.point_z);
      m_yx_r <= P1W'(q.y) * P1W'(in_chan.point_x);
      m_yy_r <= P1W'(q.y) * P1W'(in_chan.point_y);
      m_yz_r <= P1W'(q.y) * P1W'(in_chan.point_z);
      m_zx_r <= P1W'(q.z) * P1W'(in_chan.point_x);
      m_zy_r <= P1W'(q.z) * P1W'(in_chan.point_y);
      m_zz_r <= P1W'(q.z) * P1W'(in_chan.point_z);
      m_wx_r <= P1W'(q.w) * P1W'(in_chan.point_x);
      m_wy_r <= P1W'(q.w) * P1W'(in_chan.point_y);
      m_wz_r <= P1W'(q.w) * P1W'(in_chan.point_z);
      pt1_r  <= in_chan.is_point;
    end
  end

  always_comb begin
    sx = S1W'(m_yz_r) - S1W'(m_zy_r) + S1W'(m_wx_r);
    sy = S1W'(m_zx_r) + S1W'(m_wy_r) - S1W'(m_xz_r);
    sz = S1W'(m_wz_r) + S1W'(m_xy_r) - S1W'(m_yx_r);
    sw = -S1W'(m_xx_r) - S1W'(m_yy_r) - S1W'(m_zz_r);
    t_nxt.tx       = qvr_pkg::round_t(sx);
    t_nxt.ty       = qvr_pkg::round_t(sy);
    t_nxt.tz       = qvr_pkg::round_t(sz);
    t_nxt.tw       = qvr_pkg::round_t(sw);
    t_nxt.is_point = pt1_r;
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) t_r <= t_nxt;
  end

  assign t_valid = v2_r;
  assign t_word  = t_r;

endmodule

`default_nettype wire

### rtl/qvr_rprod.sv
// ----------------------------------------------------------------------------
// qvr_rprod
// Second Hamilton product r = t * conj(q): a multiply stage, then sum, round
// and saturate into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_rprod (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire qvr_pkg::quat_t  q,
  input  wire logic            t_valid,
  output logic                 t_ready,
  input  wire qvr_pkg::tvec_t  t_word,
  qvr_out_if.source            out_chan
);

  localparam int P2W = qvr_pkg::P2W;
  localparam int S2W = qvr_pkg::S2W;
  localparam int OW  = qvr_pkg::OW;
  localparam int WW  = qvr_pkg::WW;

  logic v1_r, v2_r;
  logic adv1, adv2;

  // n_<t component><q component>; conj(q) signs folded into the sums
  logic signed [P2W-1:0] n_xw_r, n_yz_r, n_zy_r, n_wx_r;
  logic signed [P2W-1:0] n_yw_r, n_zx_r, n_wy_r, n_xz_r;
  logic signed [P2W-1:0] n_zw_r, n_wz_r, n_xy_r, n_yx_r;
  logic                  pt1_r;

  logic signed [S2W-1:0] sx, sy, sz;
  qvr_pkg::sat_t         cx, cy, cz;

  logic signed [OW-1:0]  ox_r, oy_r, oz_r;
  logic        [WW-1:0]  ow_r;
  logic                  sat_r;

  assign adv2    = !v2_r || out_chan.ready;
  assign adv1    = !v1_r || adv2;
  assign t_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= t_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && t_valid) begin
      n_xw_r <= P2W'(t_word.tx) * P2W'(q.w);
      n_yz_r <= P2W'(t_word.ty) * P2W'(q.z);
      n_zy_r <= P2W'(t_word.tz) * P2W'(q.y);
      n_wx_r <= P2W'(t_word.tw) * P2W'(q.x);
      n_yw_r <= P2W'(t_word.ty) * P2W'(q.w);
      n_zx_r <= P2W'(t_word.tz) * P2W'(q.x);
      n_wy_r <= P2W'(t_word.tw) * P2W'(q.y);
      n_xz_r <= P2W'(t_word.tx) * P2W'(q.z);
      n_zw_r <= P2W'(t_word.tz) * P2W'(q.w);
      n_wz_r <= P2W'(t_word.tw) * P2W'(q.z);
      n_xy_r <= P2W'(t_word.tx) * P2W'(q.y);
      n_yx_r <= P2W'(t_word.ty) * P2W'(q.x);
      pt1_r  <= t_word.is_point;
    end
  end

  always_comb begin
    sx = S2W'(n_xw_r) - S2W'(n_yz_r) + S2W'(n_zy_r) - S2W'(n_wx_r);
    sy = S2W'(n_yw_r) - S2W'(n_zx_r) - S2W'(n_wy_r) + S2W'(n_xz_r);
    sz = S2W'(n_zw_r) - S2W'(n_wz_r) - S2W'(n_xy_r) + S2W'(n_yx_r);
    cx = qvr_pkg::sat_out(qvr_pkg::round_r(sx));
    cy = qvr_pkg::sat_out(qvr_pkg::round_r(sy));
    cz = qvr_pkg::sat_out(qvr_pkg::round_r(sz));
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      ox_r  <= cx.val;
      oy_r  <= cy.val;
      oz_r  <= cz.val;
      ow_r  <= pt1_r ? qvr_pkg::W_ONE : qvr_pkg::W_ZERO;
      sat_r <= cx.clip | cy.clip | cz.clip;
    end
  end

  assign out_chan.valid     = v2_r;
  assign out_chan.out_x     = ox_r;
  assign out_chan.out_y     = oy_r;
  assign out_chan.out_z     = oz_r;
  assign out_chan.out_w     = ow_r;
  assign out_chan.saturated = sat_r;

endmodule

`default_nettype wire

### rtl/quaternion_vector_rotate_core.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core
// Rotates a Q16.16 point by a configured Q1.14 quaternion: q * p * conj(q).
//
//   channel   dir   handshake        word
//   in_chan   in    valid/ready      point_x, point_y, point_z, is_point
//   out_chan  out   valid/ready      out_x, out_y, out_z, out_w, saturated
//   cfg_*     in    cfg_we           cfg_idx selects rot_x/y/z/w, cfg_wdata
//
// One word per cycle sustained while out_chan takes results; the pipeline is
// two multiply stages, each followed by a sum/round stage.
// Reset: synchronous rst_n; pipeline empties, quaternion returns to identity.
// Stalls: each stage advances when empty or when the stage after it moves, so
// bubbles collapse; input is taken while a result waits unless all are full.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [qvr_pkg::IDXW-1:0]     cfg_idx,
  input  wire logic [qvr_pkg::QW-1:0]       cfg_wdata,
  qvr_in_if.sink                            in_chan,
  qvr_out_if.source                         out_chan
);

  logic signed [qvr_pkg::QW-1:0] rot_x_r, rot_y_r, rot_z_r, rot_w_r;
  qvr_pkg::quat_t                q;
  qvr_pkg::tvec_t                t_word;
  logic                          t_valid, t_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= '0;
      rot_y_r <= '0;
      rot_z_r <= '0;
      rot_w_r <= qvr_pkg::ROT_W_RESET;
    end else if (cfg_we) begin
      unique case (qvr_pkg::reg_idx_t'(cfg_idx))
        qvr_pkg::REG_ROT_X: rot_x_r <= cfg_wdata;
        qvr_pkg::REG_ROT_Y: rot_y_r <= cfg_wdata;
        qvr_pkg::REG_ROT_Z: rot_z_r <= cfg_wdata;
        qvr_pkg::REG_ROT_W: rot_w_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign q.x = rot_x_r;
  assign q.y = rot_y_r;
  assign q.z = rot_z_r;
  assign q.w = rot_w_r;

  qvr_tprod u_tprod (
    .clk     (clk),
    .rst_n   (rst_n),
    .q       (q),
    .in_chan (in_chan),
    .t_valid (t_valid),
    .t_ready (t_ready),
    .t_word  (t_word)
  );

  qvr_rprod u_rprod (
    .clk      (clk),
    .rst_n    (rst_n),
    .q        (q),
    .t_valid  (t_valid),
    .t_ready  (t_ready),
    .t_word   (t_word),
    .out_chan (out_chan)
  );

  // words in flight, for the checks below
  logic [2:0] inflight_r, inflight_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) inflight_nxt = inflight_r + 3'd1;
    else if (!in_acc && out_acc) inflight_nxt = inflight_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else        inflight_r <= inflight_nxt;
  end

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd4)
    else $error("more words in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (inflight_r != 3'd0))
    else $error("result shown with no word in flight");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (inflight_r == 3'd4 && !out_chan.ready))
    else $error("input stalled while a stage is free");

  a_w_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.out_w == qvr_pkg::W_ONE || out_chan.out_w == qvr_pkg::W_ZERO))
    else $error("bad homogeneous w");

endmodule

`default_nettype wire

### dv/tb_quaternion_vector_rotate_core.sv
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate_core
// Self-checking bench for the quaternion point rotator. A directed table
// covers identity after reset, coordinate extremes, clipping, the zero,
// all-minimum and all-maximum quaternions and rotations. Random points then
// run under a series of quaternion settings, most with random idling. Each
// word out is checked against its typed result or a bit-true q * p * conj(q).
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_vector_rotate_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QW   = qvr_pkg::QW;
  localparam int PW   = qvr_pkg::PW;
  localparam int OW   = qvr_pkg::OW;
  localparam int WW   = qvr_pkg::WW;
  localparam int IDXW = qvr_pkg::IDXW;

  localparam logic [WW-1:0] W_ONE       = qvr_pkg::W_ONE;
  localparam logic [WW-1:0] W_ZERO      = qvr_pkg::W_ZERO;
  localparam logic [QW-1:0] ROT_W_RESET = qvr_pkg::ROT_W_RESET;

  typedef qvr_pkg::quat_t    quat_t;
  typedef qvr_pkg::reg_idx_t reg_idx_t;

  localparam int HANG_LIMIT    = 5000;   // cycles with no handshake at all
  localparam int RAND_PHASES   = 10;
  localparam int RAND_PER_PHASE = 70;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [OW-1:0] x;
    logic [OW-1:0] y;
    logic [OW-1:0] z;
    logic [WW-1:0] w;
    logic          sat;
  } rot_result_t;

  typedef enum bit {ROW_QUAT, ROW_POINT} row_kind_t;

  // a ROW_QUAT row loads q; a ROW_POINT row sends a point, optionally with
  // its expected result spelled out
  typedef struct packed {
    row_kind_t     kind;
    quat_t         q;
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] z;
    logic          pt;
    logic          typed;
    logic [OW-1:0] ex;
    logic [OW-1:0] ey;
    logic [OW-1:0] ez;
    logic          esat;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  dir_row_t dir_table [DIR_ROWS] = '{
    // identity quaternion straight out of reset
    '{ROW_POINT, 64'h0, 32'h0, 32'h0, 32'h0, 1'b1,
      1'b1, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h7fffffff, 32'h80000000, 32'h00000001, 1'b0,
      1'b1, 32'h7fffffff, 32'h80000000, 32'h00000001, 1'b0},
    '{ROW_POINT, 64'h0, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1,
      1'b1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0},
    '{ROW_POINT, 64'h0, 32'h55555555, 32'haaaaaaaa, 32'h00010000, 1'b0,
      1'b1, 32'h55555555, 32'haaaaaaaa, 32'h00010000, 1'b0},
    // w = -2.0: scale by 4, extremes clip
    '{ROW_QUAT, {16'h0000, 16'h0000, 16'h0000, 16'h8000},
      32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h7fffffff, 32'h80000000, 32'h00010000, 1'b1,
      1'b1, 32'h7fffffff, 32'h80000000, 32'h00040000, 1'b1},
    '{ROW_POINT, 64'h0, 32'h00000001, 32'hffffffff, 32'h0, 1'b0,
      1'b1, 32'h00000004, 32'hfffffffc, 32'h0, 1'b0},
    // zero quaternion
    '{ROW_QUAT, {16'h0000, 16'h0000, 16'h0000, 16'h0000},
      32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h7fffffff, 32'h80000000, 32'h00003039, 1'b1,
      1'b1, 32'h0, 32'h0, 32'h0, 1'b0},
    // every component -2.0: conjugate must hold +32768
    '{ROW_QUAT, {16'h8000, 16'h8000, 16'h8000, 16'h8000},
      32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h00010000, 32'h0, 32'h0, 1'b0,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'hffff0000, 32'h00020000, 32'h00000003, 1'b1,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    // ~90 degrees about z, inexact so rounding shows
    '{ROW_QUAT, {16'h0000, 16'h0000, 16'h2d41, 16'h2d41},
      32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h00010000, 32'h0, 32'h0, 1'b1,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h0, 32'h00010000, 32'h00007fff, 1'b0,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h00002000, 32'hffffe000, 32'h00000001, 1'b1,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    // every component at maximum
    '{ROW_QUAT, {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
      32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h00000001, 32'h00000001, 32'h00000001, 1'b1,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    // 180 degrees about x
    '{ROW_QUAT, {16'h4000, 16'h0000, 16'h0000, 16'h0000},
      32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h00000005, 32'h00000007, 32'hfffffff7, 1'b1,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_POINT, 64'h0, 32'h80000000, 32'h00000003, 32'h80000000, 1'b0,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDXW-1:0] cfg_idx;
  logic [QW-1:0]   cfg_wdata;

  qvr_in_if  in_if ();
  qvr_out_if out_if ();

  quaternion_vector_rotate_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  quat_t       rot_cfg;
  rot_result_t expected_rotations[$];
  bit          tx_gaps;
  bit          rx_stalls;
  int unsigned points_sent;
  int unsigned results_seen;
  int unsigned clipped_seen;
  int unsigned quat_settings;
  int unsigned mismatches;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic longint round_half_up(input longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp_to_i32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic rot_result_t rotate_point(input logic [PW-1:0] px_i, py_i, pz_i,
                                               input logic is_pt);
    longint qx, qy, qz, qw, px, py, pz;
    longint tx, ty, tz, tw, cx, cy, cz, rx, ry, rz, sx, sy, sz;
    rot_result_t res;
    qx = longint'(signed'(rot_cfg.x));
    qy = longint'(signed'(rot_cfg.y));
    qz = longint'(signed'(rot_cfg.z));
    qw = longint'(signed'(rot_cfg.w));
    px = longint'(signed'(px_i));
    py = longint'(signed'(py_i));
    pz = longint'(signed'(pz_i));
    // t = q * (p, 0)
    tx = round_half_up(qy * pz - qz * py + qw * px);
    ty = round_half_up(qz * px + qw * py - qx * pz);
    tz = round_half_up(qw * pz + qx * py - qy * px);
    tw = round_half_up(-(qx * px) - qy * py - qz * pz);
    // r = t * conj(q); negation is exact in 64 bits
    cx = -qx;
    cy = -qy;
    cz = -qz;
    rx = round_half_up(tx * qw + ty * cz - tz * cy + tw * cx);
    ry = round_half_up(ty * qw + tz * cx + tw * cy - tx * cz);
    rz = round_half_up(tz * qw + tw * cz + tx * cy - ty * cx);
    sx = clamp_to_i32(rx);
    sy = clamp_to_i32(ry);
    sz = clamp_to_i32(rz);
    res.x   = sx[OW-1:0];
    res.y   = sy[OW-1:0];
    res.z   = sz[OW-1:0];
    res.w   = is_pt ? W_ONE : W_ZERO;
    res.sat = (sx != rx) || (sy != ry) || (sz != rz);
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [PW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return PW'($urandom_range(0, 2097152)) - 32'd1048576;
      7:          return 32'h7fffffff;
      8:          return 32'h80000000;
      default:    return PW'($urandom_range(0, 32)) - 32'd16;
    endcase
  endfunction

  function automatic quat_t rand_quat();
    quat_t q;
    logic [QW-1:0] c [4];
    bit wide;
    wide = $urandom_range(0, 1);
    foreach (c[i]) begin
      case ($urandom_range(0, 9))
        0:       c[i] = 16'h8000;
        1:       c[i] = 16'h7fff;
        2:       c[i] = 16'h0000;
        default: c[i] = wide ? QW'($urandom_range(0, 65535))
                             : QW'($urandom_range(0, 16384)) - 16'd8192;
      endcase
    end
    q = {c[0], c[1], c[2], c[3]};
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH word %0d: %s", results_seen, msg);
  endtask

  // every expected word back before the quaternion may change
  task automatic settle_pipe();
    in_if.valid <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk);
  endtask

  task automatic load_rotation(input quat_t q);
    logic [QW-1:0] vals [4];
    reg_idx_t idx;
    vals = '{q.x, q.y, q.z, q.w};
    idx  = qvr_pkg::REG_ROT_X;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we  <= 1'b0;
    rot_cfg = q;
    quat_settings++;
  endtask

  task automatic send_point(input logic [PW-1:0] px, py, pz, input logic is_pt,
                            input bit typed, input rot_result_t typed_res);
    int unsigned gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.point_x  <= px;
    in_if.point_y  <= py;
    in_if.point_z  <= pz;
    in_if.is_point <= is_pt;
    do @(posedge clk); while (!in_if.ready);
    expected_rotations.push_back(typed ? typed_res : rotate_point(px, py, pz, is_pt));
    points_sent++;
  endtask

  initial begin
    rot_result_t typed_res;
    quat_t q;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = qvr_pkg::REG_ROT_X;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.point_x  = '0;
    in_if.point_y  = '0;
    in_if.point_z  = '0;
    in_if.is_point = 1'b0;
    rot_cfg        = {16'h0000, 16'h0000, 16'h0000, ROT_W_RESET};
    tx_gaps        = 1'b1;
    rx_stalls      = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_QUAT) begin
        settle_pipe();
        load_rotation(dir_table[i].q);
      end else begin
        typed_res = {dir_table[i].ex, dir_table[i].ey, dir_table[i].ez,
                     dir_table[i].pt ? W_ONE : W_ZERO, dir_table[i].esat};
        send_point(dir_table[i].x, dir_table[i].y, dir_table[i].z, dir_table[i].pt,
                   dir_table[i].typed, typed_res);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_pipe();
      case (ph)
        0:       q = {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        1:       q = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
        default: q = rand_quat();
      endcase
      load_rotation(q);
      // phase 3 mod 4 runs with no idling on either side
      tx_gaps   = (ph % 4) < 2;
      rx_stalls = (ph % 2) == 0;
      for (int n = 0; n < RAND_PER_PHASE; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                   1'b0, '0);
    end

    settle_pipe();
    repeat (8) @(posedge clk);
    if (expected_rotations.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived",
                                expected_rotations.size()));
    $display("covered %0d points (%0d random) under %0d quaternion settings",
             points_sent, RAND_PHASES * RAND_PER_PHASE, quat_settings);
    $display("checked %0d result words, %0d of them clipped", results_seen, clipped_seen);
    if (mismatches == 0) begin
      $display("tb_quaternion_vector_rotate_core: PASS");
    end else begin
      $display("tb_quaternion_vector_rotate_core: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------- sink side
  initial begin
    int unsigned stall_left;
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    rot_result_t want;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("hang: no handshake for %0d cycles, %0d words outstanding",
                 HANG_LIMIT, expected_rotations.size());
        $display("tb_quaternion_vector_rotate_core: FAIL");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_rotations.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = expected_rotations.pop_front();
          if (out_if.out_x !== want.x)
            report_mismatch($sformatf("out_x got %h want %h", out_if.out_x, want.x));
          if (out_if.out_y !== want.y)
            report_mismatch($sformatf("out_y got %h want %h", out_if.out_y, want.y));
          if (out_if.out_z !== want.z)
            report_mismatch($sformatf("out_z got %h want %h", out_if.out_z, want.z));
          if (out_if.out_w !== want.w)
            report_mismatch($sformatf("out_w got %h want %h", out_if.out_w, want.w));
          if (out_if.saturated !== want.sat)
            report_mismatch($sformatf("saturated got %b want %b",
                                      out_if.saturated, want.sat));
          if (want.sat) clipped_seen++;
        end
        results_seen++;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule

`default_nettype wire
